// ----- hdl/wsht_pkg.sv -----
package wsht_pkg;

	localparam int unsigned XW = 12;
	localparam int unsigned YW = 11;
	localparam int unsigned NUMW = 5;

	typedef struct packed {
		logic          action;
		logic [XW-1:0] left;
		logic [YW-1:0] top;
		logic [XW-1:0] right;
		logic [YW-1:0] bottom;
		logic [XW-1:0] point_x;
		logic [YW-1:0] point_y;
	} item_t;

	typedef struct packed {
		logic            hit;
		logic [NUMW-1:0] window_number;
	} result_t;

	typedef struct packed {
		logic [XW-1:0] left;
		logic [YW-1:0] top;
		logic [XW-1:0] right;
		logic [YW-1:0] bottom;
	} rect_t;

	localparam int unsigned RECTW = $bits(rect_t);

	localparam logic ACT_DEFINE = 1'b0;
	localparam logic ACT_CLICK  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_PLACE
	} state_t;

	typedef struct packed {
		logic accept;
		logic scan;
		logic shift;
		logic place;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic miss;
		logic shift_done;
	} sts_t;

endpackage

// ----- hdl/wsht_ram.sv -----
module wsht_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/wsht_ctrl.sv -----
module wsht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          action,
	input  wsht_pkg::sts_t sts,
	output wsht_pkg::cmd_t cmd,
	output logic          busy
);

	wsht_pkg::state_t state_q;
	wsht_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsht_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			wsht_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.accept = start;
				if (start && action == wsht_pkg::ACT_CLICK) begin
					state_d = wsht_pkg::ST_SCAN;
				end
			end
			wsht_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					state_d = wsht_pkg::ST_SHIFT;
				end else if (sts.miss) begin
					state_d = wsht_pkg::ST_IDLE;
				end
			end
			wsht_pkg::ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.shift_done) begin
					state_d = wsht_pkg::ST_PLACE;
				end
			end
			wsht_pkg::ST_PLACE: begin
				cmd.place = 1'b1;
				state_d = wsht_pkg::ST_IDLE;
			end
			default: begin
				state_d = wsht_pkg::ST_IDLE;
			end
		endcase
	end

	a_hit_goes_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wsht_pkg::ST_SCAN && sts.hit) |=> state_q == wsht_pkg::ST_SHIFT)
		else $error("hit did not start the raise");

	a_shift_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == wsht_pkg::ST_SHIFT) |-> $past(state_q) == wsht_pkg::ST_SCAN)
		else $error("raise entered without a scan");

	a_busy_outside_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != wsht_pkg::ST_IDLE) |-> busy)
		else $error("busy low while a click is in progress");

endmodule

// ----- hdl/wsht_dp.sv -----
module wsht_dp #(
	parameter int unsigned MAX_WINDOWS   = 16,
	parameter int unsigned SCREEN_WIDTH  = 2560,
	parameter int unsigned SCREEN_HEIGHT = 1440
) (
	input  logic             clk,
	input  logic             arst_n,
	input  wsht_pkg::item_t   item,
	input  wsht_pkg::cmd_t    cmd,
	output wsht_pkg::sts_t    sts,
	output wsht_pkg::result_t result,
	output logic             strobe
);

	localparam int unsigned AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int unsigned CW = $clog2(MAX_WINDOWS + 1);
	localparam int unsigned EW = AW + wsht_pkg::RECTW;
	localparam int unsigned SW = 14;

	logic [CW-1:0] count_q;
	logic [CW-1:0] remaining_q;
	logic [CW-1:0] rd_ptr_q;
	logic [wsht_pkg::XW-1:0] px_q;
	logic [wsht_pkg::YW-1:0] py_q;
	logic          vld_s1;
	logic [AW-1:0] pos_s1;
	logic          wvld_s1;
	logic [AW-1:0] wadr_s1;
	logic [EW-1:0] hit_q;
	wsht_pkg::result_t res_q;
	logic          res_vld_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic [AW-1:0] raddr;
	logic [EW-1:0] rdata;
	logic [CW-1:0] rem_m1;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] ptr_m1;
	logic          define_wr;
	logic          offscreen;
	logic          issue;
	logic          sh_issue;
	logic          holds;
	logic          hit_now;
	logic          miss_now;
	wsht_pkg::rect_t rect;
	logic [AW-1:0] ent_idx;
	wsht_pkg::rect_t new_rect;

	assign rem_m1 = remaining_q - CW'(1);
	assign cnt_m1 = count_q - CW'(1);
	assign ptr_m1 = rd_ptr_q - CW'(1);

	assign define_wr = cmd.accept && item.action == wsht_pkg::ACT_DEFINE
		&& count_q != CW'(MAX_WINDOWS);
	assign offscreen = ({{(SW-wsht_pkg::XW){1'b0}}, item.point_x} >= SW'(SCREEN_WIDTH))
		|| ({{(SW-wsht_pkg::YW){1'b0}}, item.point_y} >= SW'(SCREEN_HEIGHT));

	assign issue    = cmd.scan && remaining_q != '0;
	assign sh_issue = cmd.shift && rd_ptr_q != count_q;

	assign rect    = rdata[wsht_pkg::RECTW-1:0];
	assign ent_idx = rdata[EW-1:wsht_pkg::RECTW];
	assign holds   = px_q >= rect.left && px_q <= rect.right
		&& py_q >= rect.top && py_q <= rect.bottom;

	assign hit_now  = cmd.scan && vld_s1 && holds;
	assign miss_now = cmd.scan && !hit_now
		&& ((vld_s1 && pos_s1 == '0) || (!vld_s1 && remaining_q == '0));

	assign sts.hit        = hit_now;
	assign sts.miss       = miss_now;
	assign sts.shift_done = cmd.shift && !sh_issue && !wvld_s1;

	assign new_rect.left   = item.left;
	assign new_rect.top    = item.top;
	assign new_rect.right  = item.right;
	assign new_rect.bottom = item.bottom;

	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = {count_q[AW-1:0], new_rect};
		if (define_wr) begin
			we = 1'b1;
		end else if (wvld_s1) begin
			we    = 1'b1;
			waddr = wadr_s1;
			wdata = rdata;
		end else if (cmd.place) begin
			we    = 1'b1;
			waddr = cnt_m1[AW-1:0];
			wdata = hit_q;
		end
		raddr = cmd.shift ? rd_ptr_q[AW-1:0] : rem_m1[AW-1:0];
	end

	wsht_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_WINDOWS)
	) u_stack_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			remaining_q <= '0;
			rd_ptr_q    <= '0;
			vld_s1      <= 1'b0;
			wvld_s1     <= 1'b0;
			res_vld_q   <= 1'b0;
		end else begin
			wvld_s1   <= sh_issue;
			res_vld_q <= hit_now || miss_now;
			if (define_wr) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.accept && item.action == wsht_pkg::ACT_CLICK) begin
				remaining_q <= offscreen ? '0 : count_q;
				vld_s1      <= 1'b0;
			end else if (hit_now) begin
				remaining_q <= '0;
				vld_s1      <= 1'b0;
				rd_ptr_q    <= CW'(pos_s1) + CW'(1);
			end else if (cmd.scan) begin
				vld_s1 <= issue;
				if (issue) begin
					remaining_q <= rem_m1;
				end
			end else if (sh_issue) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q <= item.point_x;
			py_q <= item.point_y;
		end
		if (issue) begin
			pos_s1 <= rem_m1[AW-1:0];
		end
		if (sh_issue) begin
			wadr_s1 <= ptr_m1[AW-1:0];
		end
		if (hit_now) begin
			hit_q <= rdata;
		end
		res_q.hit           <= hit_now;
		res_q.window_number <= hit_now
			? wsht_pkg::NUMW'(ent_idx) + wsht_pkg::NUMW'(1) : '0;
	end

	assign result = res_q;
	assign strobe = res_vld_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_WINDOWS))
		else $error("window count beyond capacity");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wvld_s1 |-> CW'(wadr_s1) < count_q)
		else $error("raise wrote outside the defined windows");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && !res_q.hit) |-> res_q.window_number == '0)
		else $error("miss reported a window number");

endmodule

// ----- hdl/window_stack_hit_test_unit.sv -----
// A define beat is taken while idle and busy stays low, so defines can follow back to back.
// A click beat over n stacked windows scans from the top, one window per cycle through the
// stack RAM read port; the result strobe is registered from the hit or miss decision.
// A hit then raises the window by moving entries one per cycle, and a click holds busy until
// the raise is done. Results are shown for one cycle only, since the receiver cannot stall.
// Reset empties the stack at once; the stack RAM itself is not cleared.
module window_stack_hit_test_unit #(
	parameter int unsigned MAX_WINDOWS   = 16,
	parameter int unsigned SCREEN_WIDTH  = 2560,
	parameter int unsigned SCREEN_HEIGHT = 1440
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  wsht_pkg::item_t   item,
	output wsht_pkg::result_t result,
	output logic             strobe
);

	wsht_pkg::cmd_t cmd;
	wsht_pkg::sts_t sts;

	wsht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (item.action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	wsht_dp #(
		.MAX_WINDOWS   (MAX_WINDOWS),
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result),
		.strobe (strobe)
	);

endmodule
